/* rtl/afa_pkg.sv */
// Shared types, constants and the quarter-wave sine table for the audio feature analyzer.
package afa_pkg;

  localparam int unsigned WINDOW     = 4096;
  localparam int unsigned WIN_AW     = 12;
  localparam int unsigned WIN_CW     = 13;
  localparam int unsigned MAX_BINS   = 256;
  localparam int unsigned MAX_FRAMES = 2097152;
  localparam int unsigned QUARTER    = 1024;
  localparam int unsigned QTAB_DEPTH = 1025;
  localparam int unsigned QTAB_AW    = 11;
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned ACC_W      = 44;
  localparam int unsigned RATE_W     = 18;

  localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint ROT_COS = 64'sd1073740561;
  localparam longint ROT_SIN = 64'sd1647099;

  typedef struct packed {
    logic signed [15:0] sample_value;
    logic               last;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        peak_level;
    logic [15:0]        rms_level;
    logic [19:0]        peak_rms_ratio;
    logic signed [15:0] mean_level;
    logic [15:0]        crossing_rate;
    logic [23:0]        attack_us;
    logic [16:0]        centroid_hz;
    logic [21:0]        frame_total;
  } out_word_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] value;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic              en;
    logic [WIN_AW-1:0] addr;
    logic [15:0]       data;
  } win_wr_t;

  typedef struct packed {
    logic              start;
    logic [WIN_CW-1:0] w;
    logic [WIN_AW-1:0] dq;
    logic [WIN_CW-1:0] dr;
  } dft_cmd_t;

  typedef struct packed {
    logic                    done;
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } dft_rsp_t;

  typedef logic [QTAB_DEPTH-1:0][14:0] qtab_t;

  // Quarter-wave sine in unsigned Q0.15, built from a Q2.30 rotation recurrence.
  function automatic qtab_t build_qtab();
    qtab_t  t;
    longint c;
    longint s;
    longint q;
    longint nc;
    longint ns;
    c = Q30_ONE;
    s = 0;
    t = '0;
    for (int j = 0; j < QTAB_DEPTH; j++) begin
      q = (s + 64'sd16384) / 64'sd32768;
      if (q < 0) q = 0;
      if (q > 64'sd32767) q = 64'sd32767;
      t[j] = q[14:0];
      nc = (c * ROT_COS - s * ROT_SIN + Q30_ONE / 2) / Q30_ONE;
      ns = (s * ROT_COS + c * ROT_SIN + Q30_ONE / 2) / Q30_ONE;
      c = nc;
      s = ns;
    end
    return t;
  endfunction

endpackage

/* rtl/afa_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module afa_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  afa_pkg::div_req_t  req_i,
  output afa_pkg::div_rsp_t  rsp_o
);

  logic [afa_pkg::DIV_W-1:0] num_q, num_d;
  logic [afa_pkg::DIV_W-1:0] rem_q, rem_d;
  logic [afa_pkg::DIV_W-1:0] den_q;
  logic [5:0]                cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [afa_pkg::DIV_W:0]   rem_sh;
  logic                      fits;

  always_comb begin
    rem_sh = {rem_q, num_q[afa_pkg::DIV_W-1]};
    fits   = rem_sh >= {1'b0, den_q};
    rem_d  = fits ? afa_pkg::DIV_W'(rem_sh - {1'b0, den_q})
                  : rem_sh[afa_pkg::DIV_W-1:0];
    num_d  = {num_q[afa_pkg::DIV_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        num_q  <= req_i.num;
        den_q  <= req_i.den;
        rem_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        num_q <= num_d;
        rem_q <= rem_d;
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == '1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
  assign rsp_o.rem  = rem_q;

endmodule

/* rtl/afa_sqrt.sv */
// Integer square root that retires two radicand bits per cycle.
module afa_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  afa_pkg::sqrt_req_t  req_i,
  output afa_pkg::sqrt_rsp_t  rsp_o
);

  logic [afa_pkg::DIV_W-1:0] val_q;
  logic [afa_pkg::DIV_W-1:0] res_q;
  logic [afa_pkg::DIV_W-1:0] bit_q;
  logic [afa_pkg::DIV_W-1:0] trial;
  logic                      busy_q;
  logic                      done_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      res_q  <= '0;
      bit_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        val_q  <= req_i.value;
        res_q  <= '0;
        bit_q  <= {2'b01, {(afa_pkg::DIV_W-2){1'b0}}};
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (val_q >= trial) begin
          val_q <= val_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q[0]) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = res_q[31:0];

endmodule

/* rtl/afa_dft.sv */
// Window sample memory, sine table memory and the single-bin DFT walk over the window.
module afa_dft (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  afa_pkg::win_wr_t   wr_i,
  input  afa_pkg::dft_cmd_t  cmd_i,
  output afa_pkg::dft_rsp_t  rsp_o
);

  localparam afa_pkg::qtab_t QTAB = afa_pkg::build_qtab();

  logic [15:0] mem [0:afa_pkg::WINDOW-1];

  logic                       act_q;
  logic [afa_pkg::WIN_CW-1:0] cnt_q;
  logic [afa_pkg::WIN_AW-1:0] ph_q;
  logic [afa_pkg::WIN_CW-1:0] r_q;
  logic [afa_pkg::WIN_CW-1:0] w_q;
  logic [afa_pkg::WIN_AW-1:0] dq_q;
  logic [afa_pkg::WIN_CW-1:0] dr_q;
  logic                       v1_q, l1_q, v2_q, l2_q, done_q;

  logic [15:0] x_q;
  logic [14:0] sraw_q, craw_q;
  logic        sneg_q, cneg_q;
  logic signed [31:0] prodc_q, prods_q;
  logic signed [afa_pkg::ACC_W-1:0] re_q, im_q;

  logic [afa_pkg::WIN_AW-1:0]  idx_c;
  logic [afa_pkg::QTAB_AW-1:0] addr_s, addr_c;
  logic [afa_pkg::WIN_CW-1:0]  r_sum;
  logic                        last_issue;
  logic signed [16:0]          sv, cv;

  always_comb begin
    // The cosine is the sine a quarter turn ahead.
    idx_c  = ph_q + afa_pkg::WIN_AW'(afa_pkg::QUARTER);
    addr_s = ph_q[10] ? afa_pkg::QTAB_AW'(afa_pkg::QUARTER) - {1'b0, ph_q[9:0]}
                      : {1'b0, ph_q[9:0]};
    addr_c = idx_c[10] ? afa_pkg::QTAB_AW'(afa_pkg::QUARTER) - {1'b0, idx_c[9:0]}
                       : {1'b0, idx_c[9:0]};
    r_sum      = r_q + dr_q;
    last_issue = cnt_q == (w_q - afa_pkg::WIN_CW'(1));
    sv = sneg_q ? -$signed({2'b00, sraw_q}) : $signed({2'b00, sraw_q});
    cv = cneg_q ? -$signed({2'b00, craw_q}) : $signed({2'b00, craw_q});
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (act_q) begin
      x_q    <= mem[cnt_q[afa_pkg::WIN_AW-1:0]];
      sraw_q <= QTAB[addr_s];
      craw_q <= QTAB[addr_c];
      sneg_q <= ph_q[11];
      cneg_q <= idx_c[11];
    end
    if (v1_q) begin
      prodc_q <= 32'($signed(x_q)) * 32'(cv);
      prods_q <= 32'($signed(x_q)) * 32'(sv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      cnt_q  <= '0;
      ph_q   <= '0;
      r_q    <= '0;
      w_q    <= '0;
      dq_q   <= '0;
      dr_q   <= '0;
      v1_q   <= 1'b0;
      l1_q   <= 1'b0;
      v2_q   <= 1'b0;
      l2_q   <= 1'b0;
      done_q <= 1'b0;
      re_q   <= '0;
      im_q   <= '0;
    end else begin
      done_q <= 1'b0;
      v1_q   <= act_q;
      l1_q   <= act_q && last_issue;
      v2_q   <= v1_q;
      l2_q   <= v1_q && l1_q;
      if (cmd_i.start) begin
        act_q <= 1'b1;
        cnt_q <= '0;
        ph_q  <= '0;
        r_q   <= cmd_i.w >> 1;
        w_q   <= cmd_i.w;
        dq_q  <= cmd_i.dq;
        dr_q  <= cmd_i.dr;
        re_q  <= '0;
        im_q  <= '0;
      end else if (act_q) begin
        // Rounded phase index tracked as quotient and remainder of the step.
        if (r_sum >= w_q) begin
          r_q  <= r_sum - w_q;
          ph_q <= ph_q + dq_q + afa_pkg::WIN_AW'(1);
        end else begin
          r_q  <= r_sum;
          ph_q <= ph_q + dq_q;
        end
        cnt_q <= cnt_q + afa_pkg::WIN_CW'(1);
        if (last_issue) begin
          act_q <= 1'b0;
        end
      end
      if (v2_q) begin
        re_q <= re_q + afa_pkg::ACC_W'(prodc_q);
        im_q <= im_q - afa_pkg::ACC_W'(prods_q);
        if (l2_q) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.re   = re_q;
  assign rsp_o.im   = im_q;

endmodule

/* rtl/audio_feature_analyzer.sv */
// Samples stream in at one word per cycle while the clip statistics accumulate.
// After the word marked last, input is held off while the report is computed:
// divider and root work plus, per DFT bin, a one-sample-per-cycle walk over the w
// window samples (w = min(frames, 4096), up to 255 bins).
// The finished report waits in an output register while the next clip streams in.
// Reset clears the accumulators and sets the rate to 48000; window memory is not cleared.
module audio_feature_analyzer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  afa_pkg::in_word_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output afa_pkg::out_word_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [afa_pkg::RATE_W-1:0]    cfg_data_i
);

  typedef enum logic [4:0] {
    ST_COLLECT, ST_REPORT, ST_RMS_DIV, ST_RMS_SQRT, ST_CREST_DIV, ST_DC_DIV,
    ST_CR_DIV, ST_ATT_DIV, ST_BIN_CHECK, ST_BIN_DIV, ST_WALK, ST_SQUARE,
    ST_SQRT, ST_CEN_MUL, ST_CEN_SUM, ST_CEN_RND, ST_CEN_DIV, ST_EMIT
  } state_e;

  state_e state_q;

  logic [afa_pkg::RATE_W-1:0] rate_q;

  // Clip accumulators.
  logic signed [37:0] sum_q;
  logic [51:0]        sumsq_q;
  logic [16:0]        peak_q;
  logic [20:0]        pos_q;
  logic [20:0]        sc_q;
  logic               prevneg_q;
  logic [21:0]        frames_q;

  // Report and centroid working registers.
  logic [15:0]        rms_q;
  logic [19:0]        crest_q;
  logic signed [15:0] dc_q;
  logic [15:0]        cr_q;
  logic [23:0]        att_q;
  logic [16:0]        cen_q;
  logic [40:0]        att_prod_q;
  logic [afa_pkg::WIN_CW-1:0] w_q;
  logic [8:0]         k_q;
  logic [27:0]        rs_q, is_q;
  logic [35:0]        msum_q;
  logic [43:0]        wsum_q;
  logic [39:0]        plo_q, phi_q;
  logic [30:0]        dlo_q, dhi_q;
  logic [62:0]        cnum_q;
  logic [48:0]        cden_q;

  afa_pkg::out_word_t out_q;
  logic               out_valid_q;

  afa_pkg::div_req_t  div_req_q;
  afa_pkg::div_rsp_t  div_rsp;
  afa_pkg::sqrt_req_t sqrt_req_q;
  afa_pkg::sqrt_rsp_t sqrt_rsp;
  afa_pkg::dft_cmd_t  dft_cmd_q;
  afa_pkg::dft_rsp_t  dft_rsp;
  afa_pkg::win_wr_t   win_wr;

  logic               in_fire;
  logic               room;
  logic               emit_go;
  logic signed [15:0] x;
  logic signed [16:0] xe;
  logic [16:0]        absx;
  logic signed [31:0] sq;
  logic [37:0]        abs_sum;
  logic [43:0]        abs_re, abs_im;
  logic [55:0]        sq_re, sq_im;
  logic [43:0]        wk;
  logic [27:0]        mag;

  assign in_ready_o = state_q == ST_COLLECT;
  assign in_fire    = in_valid_i && in_ready_o;
  assign room       = frames_q < 22'(afa_pkg::MAX_FRAMES);
  assign emit_go    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    x       = in_data_i.sample_value;
    xe      = 17'(x);
    absx    = xe[16] ? 17'(-xe) : 17'(xe);
    sq      = 32'(x) * 32'(x);
    abs_sum = sum_q[37] ? 38'(-sum_q) : 38'(sum_q);
    abs_re  = dft_rsp.re[afa_pkg::ACC_W-1] ? 44'(-dft_rsp.re) : 44'(dft_rsp.re);
    abs_im  = dft_rsp.im[afa_pkg::ACC_W-1] ? 44'(-dft_rsp.im) : 44'(dft_rsp.im);
    sq_re   = 56'(rs_q) * 56'(rs_q);
    sq_im   = 56'(is_q) * 56'(is_q);
    mag     = sqrt_rsp.root[27:0];
    wk      = 44'(mag) * 44'(k_q);
    win_wr.en   = in_fire && frames_q < 22'(afa_pkg::WINDOW);
    win_wr.addr = frames_q[afa_pkg::WIN_AW-1:0];
    win_wr.data = in_data_i.sample_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= afa_pkg::RATE_RESET;
    end else if (cfg_we_i) begin
      rate_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      sumsq_q   <= '0;
      peak_q    <= '0;
      pos_q     <= '0;
      sc_q      <= '0;
      prevneg_q <= 1'b0;
      frames_q  <= '0;
    end else if (emit_go) begin
      sum_q     <= '0;
      sumsq_q   <= '0;
      peak_q    <= '0;
      pos_q     <= '0;
      sc_q      <= '0;
      prevneg_q <= 1'b0;
      frames_q  <= '0;
    end else if (in_fire && room) begin
      sum_q   <= sum_q + 38'(x);
      sumsq_q <= sumsq_q + 52'(sq[30:0]);
      if (absx > peak_q) begin
        peak_q <= absx;
        pos_q  <= frames_q[20:0];
      end
      if (frames_q != '0 && xe[16] != prevneg_q && sc_q != '1) begin
        sc_q <= sc_q + 21'd1;
      end
      prevneg_q <= xe[16];
      frames_q  <= frames_q + 22'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      div_req_q   <= '0;
      sqrt_req_q  <= '0;
      dft_cmd_q   <= '0;
      rms_q       <= '0;
      crest_q     <= '0;
      dc_q        <= '0;
      cr_q        <= '0;
      att_q       <= '0;
      cen_q       <= '0;
      att_prod_q  <= '0;
      w_q         <= '0;
      k_q         <= '0;
      rs_q        <= '0;
      is_q        <= '0;
      msum_q      <= '0;
      wsum_q      <= '0;
      plo_q       <= '0;
      phi_q       <= '0;
      dlo_q       <= '0;
      dhi_q       <= '0;
      cnum_q      <= '0;
      cden_q      <= '0;
    end else begin
      div_req_q.start  <= 1'b0;
      sqrt_req_q.start <= 1'b0;
      dft_cmd_q.start  <= 1'b0;
      if (out_valid_q && out_ready_i && !emit_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_COLLECT: begin
          if (in_fire && in_data_i.last) begin
            state_q <= ST_REPORT;
          end
        end
        ST_REPORT: begin
          w_q        <= frames_q < 22'(afa_pkg::WINDOW) ? frames_q[afa_pkg::WIN_CW-1:0]
                                                         : afa_pkg::WIN_CW'(afa_pkg::WINDOW);
          att_prod_q <= 41'(pos_q) * 41'(20'd1000000);
          div_req_q  <= '{start: 1'b1, num: 64'(sumsq_q), den: 64'(frames_q)};
          state_q    <= ST_RMS_DIV;
        end
        ST_RMS_DIV: begin
          if (div_rsp.done) begin
            sqrt_req_q <= '{start: 1'b1, value: div_rsp.quot};
            state_q    <= ST_RMS_SQRT;
          end
        end
        ST_RMS_SQRT: begin
          if (sqrt_rsp.done) begin
            rms_q <= sqrt_rsp.root[15:0];
            if (sqrt_rsp.root == '0) begin
              // Silent clip: crest is full scale for any nonzero peak.
              crest_q   <= (peak_q != '0) ? '1 : '0;
              div_req_q <= '{start: 1'b1, num: (64'(abs_sum) << 1) + 64'(frames_q),
                             den: 64'(frames_q) << 1};
              state_q   <= ST_DC_DIV;
            end else begin
              div_req_q <= '{start: 1'b1, num: 64'({peak_q, 8'd0}),
                             den: 64'(sqrt_rsp.root)};
              state_q   <= ST_CREST_DIV;
            end
          end
        end
        ST_CREST_DIV: begin
          if (div_rsp.done) begin
            crest_q   <= (div_rsp.quot > 64'd1048575) ? '1 : div_rsp.quot[19:0];
            div_req_q <= '{start: 1'b1, num: (64'(abs_sum) << 1) + 64'(frames_q),
                           den: 64'(frames_q) << 1};
            state_q   <= ST_DC_DIV;
          end
        end
        ST_DC_DIV: begin
          if (div_rsp.done) begin
            if (sum_q[37]) begin
              dc_q <= (div_rsp.quot > 64'd32768) ? 16'sh8000
                                                 : 16'(-$signed(17'(div_rsp.quot[16:0])));
            end else begin
              dc_q <= (div_rsp.quot > 64'd32767) ? 16'sh7fff : $signed(div_rsp.quot[15:0]);
            end
            div_req_q <= '{start: 1'b1, num: 64'({sc_q, 16'd0}), den: 64'(frames_q)};
            state_q   <= ST_CR_DIV;
          end
        end
        ST_CR_DIV: begin
          if (div_rsp.done) begin
            cr_q      <= (div_rsp.quot > 64'd65535) ? '1 : div_rsp.quot[15:0];
            div_req_q <= '{start: 1'b1, num: 64'(att_prod_q),
                           den: (rate_q == '0) ? 64'd1 : 64'(rate_q)};
            state_q   <= ST_ATT_DIV;
          end
        end
        ST_ATT_DIV: begin
          if (div_rsp.done) begin
            att_q   <= (div_rsp.quot > 64'd16777215) ? '1 : div_rsp.quot[23:0];
            k_q     <= 9'd1;
            msum_q  <= '0;
            wsum_q  <= '0;
            state_q <= ST_BIN_CHECK;
          end
        end
        ST_BIN_CHECK: begin
          if (k_q < 9'(afa_pkg::MAX_BINS) && 13'(k_q) < (w_q >> 1)) begin
            div_req_q <= '{start: 1'b1, num: 64'(k_q) << 12, den: 64'(w_q)};
            state_q   <= ST_BIN_DIV;
          end else begin
            state_q <= ST_CEN_MUL;
          end
        end
        ST_BIN_DIV: begin
          if (div_rsp.done) begin
            dft_cmd_q <= '{start: 1'b1, w: w_q, dq: div_rsp.quot[afa_pkg::WIN_AW-1:0],
                           dr: div_rsp.rem[afa_pkg::WIN_CW-1:0]};
            state_q   <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (dft_rsp.done) begin
            // Truncating the sums toward zero keeps the magnitude's floor.
            rs_q    <= abs_re[42:15];
            is_q    <= abs_im[42:15];
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          sqrt_req_q <= '{start: 1'b1, value: 64'(sq_re) + 64'(sq_im)};
          state_q    <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sqrt_rsp.done) begin
            msum_q  <= msum_q + 36'(mag);
            wsum_q  <= wsum_q + wk;
            k_q     <= k_q + 9'd1;
            state_q <= ST_BIN_CHECK;
          end
        end
        ST_CEN_MUL: begin
          if (msum_q == '0) begin
            cen_q   <= '0;
            state_q <= ST_EMIT;
          end else begin
            plo_q   <= 40'(wsum_q[21:0]) * 40'(rate_q);
            phi_q   <= 40'(wsum_q[43:22]) * 40'(rate_q);
            dlo_q   <= 31'(msum_q[17:0]) * 31'(w_q);
            dhi_q   <= 31'(msum_q[35:18]) * 31'(w_q);
            state_q <= ST_CEN_SUM;
          end
        end
        ST_CEN_SUM: begin
          cnum_q  <= 63'(plo_q) + (63'(phi_q) << 22);
          cden_q  <= 49'(dlo_q) + (49'(dhi_q) << 18);
          state_q <= ST_CEN_RND;
        end
        ST_CEN_RND: begin
          div_req_q <= '{start: 1'b1, num: 64'(cnum_q) + 64'(cden_q >> 1),
                         den: 64'(cden_q)};
          state_q   <= ST_CEN_DIV;
        end
        ST_CEN_DIV: begin
          if (div_rsp.done) begin
            cen_q   <= (div_rsp.quot > 64'd131071) ? '1 : div_rsp.quot[16:0];
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_q.peak_level     <= peak_q[15:0];
            out_q.rms_level      <= rms_q;
            out_q.peak_rms_ratio <= crest_q;
            out_q.mean_level     <= dc_q;
            out_q.crossing_rate  <= cr_q;
            out_q.attack_us      <= att_q;
            out_q.centroid_hz    <= cen_q;
            out_q.frame_total    <= frames_q;
            out_valid_q          <= 1'b1;
            state_q              <= ST_COLLECT;
          end
        end
        default: begin
          state_q <= ST_COLLECT;
        end
      endcase
    end
  end

  afa_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  afa_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req_q),
    .rsp_o  (sqrt_rsp)
  );

  afa_dft u_dft (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (win_wr),
    .cmd_i  (dft_cmd_q),
    .rsp_o  (dft_rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
